// ===== rtl/layn_pkg.sv =====
// ----------------------------------------------------------------------------
// layn_pkg
// Shared widths, register indexes and saturation helper for the row
// layer normalization block.
// ----------------------------------------------------------------------------
package layn_pkg;

  localparam int DATA_W     = 32;
  localparam int MAX_ROW    = 64;
  localparam int ADDR_W     = 6;
  localparam int CNT_W      = 7;
  localparam int SUM_W      = 38;
  localparam int ACC_W      = 54;
  localparam int DIV_NUM_W  = 56;
  localparam int DIV_DEN_W  = 25;
  localparam int DIV_CNT_W  = 6;
  localparam int SQ_RAD_W   = 50;
  localparam int SQ_ROOT_W  = 25;
  localparam int SQ_REM_W   = 26;
  localparam int SQ_CNT_W   = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int EPS_W      = 16;
  localparam int MEM_W      = 3 * DATA_W;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EPSILON    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_SCALE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_BIAS   = 3'd3;

  localparam logic [CNT_W-1:0] ROW_LEN_RESET = 7'd64;
  localparam logic [EPS_W-1:0] EPS_RESET     = 16'd1;

  localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // Apply a sign to a magnitude and clip to the signed data range.
  function automatic logic signed [DATA_W-1:0] sat_mag(input logic neg,
                                                     input logic [DIV_NUM_W-1:0] m);
    logic [DIV_NUM_W-1:0] lim_pos;
    logic [DIV_NUM_W-1:0] lim_neg;
    logic signed [DATA_W-1:0] r;
    lim_pos = {{(DIV_NUM_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    lim_neg = lim_pos + 1'b1;
    if (neg) begin
      if (m > lim_neg) r = DATA_MIN;
      else r = -$signed(m[DATA_W-1:0]);
    end else begin
      if (m > lim_pos) r = DATA_MAX;
      else r = $signed(m[DATA_W-1:0]);
    end
    return r;
  endfunction

endpackage

// ===== rtl/layn_div.sv =====
// ----------------------------------------------------------------------------
// layn_div
// Restoring divider, one quotient bit per cycle, shared by mean, variance
// and per-element normalization.
// ----------------------------------------------------------------------------
module layn_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [layn_pkg::DIV_NUM_W-1:0]  num,
  input  logic [layn_pkg::DIV_DEN_W-1:0]  den,
  output logic                            done,
  output logic [layn_pkg::DIV_NUM_W-1:0]  quo
);
  import layn_pkg::*;

  logic                   busy_r;
  logic                   done_r;
  logic [DIV_CNT_W-1:0]   cnt_r;
  logic [DIV_NUM_W-1:0]   num_r;
  logic [DIV_NUM_W-1:0]   quo_r;
  logic [DIV_DEN_W-1:0]   den_r;
  logic [DIV_DEN_W-1:0]   rem_r;
  logic [DIV_DEN_W:0]     rem_sh;
  logic                   ge;
  logic [DIV_DEN_W:0]     rem_sub;

  assign rem_sh  = {rem_r, num_r[DIV_NUM_W-1]};
  assign ge      = rem_sh >= {1'b0, den_r};
  assign rem_sub = rem_sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: shift one numerator bit into the remainder per step
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[DIV_NUM_W-2:0], 1'b0};
      rem_r <= ge ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
      quo_r <= {quo_r[DIV_NUM_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ===== rtl/layn_sqrt.sv =====
// ----------------------------------------------------------------------------
// layn_sqrt
// Digit-by-digit integer square root, one root bit per cycle (floor).
// ----------------------------------------------------------------------------
module layn_sqrt (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [layn_pkg::SQ_RAD_W-1:0]   rad,
  output logic                            done,
  output logic [layn_pkg::SQ_ROOT_W-1:0]  root
);
  import layn_pkg::*;

  logic                  busy_r;
  logic                  done_r;
  logic [SQ_CNT_W-1:0]   cnt_r;
  logic [SQ_RAD_W-1:0]   rad_r;
  logic [SQ_REM_W-1:0]   rem_r;
  logic [SQ_ROOT_W-1:0]  root_r;
  logic [SQ_REM_W+1:0]   rem_sh;
  logic [SQ_REM_W+1:0]   trial;
  logic [SQ_REM_W+1:0]   rem_sub;
  logic                  ge;

  assign rem_sh  = {rem_r, rad_r[SQ_RAD_W-1 -: 2]};
  assign trial   = {1'b0, root_r, 2'b01};
  assign ge      = rem_sh >= trial;
  assign rem_sub = rem_sh - trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == SQ_CNT_W'(SQ_ROOT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= rad;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[SQ_RAD_W-3:0], 2'b00};
      rem_r  <= ge ? rem_sub[SQ_REM_W-1:0] : rem_sh[SQ_REM_W-1:0];
      root_r <= {root_r[SQ_ROOT_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ===== rtl/layer_normalization_row.sv =====
// ----------------------------------------------------------------------------
// layer_normalization_row
// Row layer normalization in signed Q16.16 with buffered two-pass statistics.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one row element with the scale
//   and bias of its column. Elements are written into a 64-entry row buffer
//   until row_length have arrived; in_stall is low only while the block
//   gathers a row, one transaction per cycle.
//   When the row completes, in_stall rises and the block runs:
//     mean division      (shared bit-serial divider)
//     variance pass      read, square and accumulate each element, then a division
//     root               (bit-serial square root)
//     emit pass          per element, a division by the root, then scale and bias
//   Each result transaction carries normalized, the row mean, the variance
//   and last_of_row on the final element. A stalled result holds in the
//   output register and the emit pass waits for it.
//   The cfg channel is always ready; write it only while the block is idle.
//   Reset (synchronous, active low) returns the registers to their defaults,
//   empties the partial row and drops any pending result. The row buffer
//   needs no clearing: only entries written in the current row are read.
// ----------------------------------------------------------------------------
module layer_normalization_row (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [layn_pkg::DATA_W-1:0]     in_value,
  input  logic signed [layn_pkg::DATA_W-1:0]     in_scale_value,
  input  logic signed [layn_pkg::DATA_W-1:0]     in_bias_value,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [layn_pkg::DATA_W-1:0]     out_normalized,
  output logic signed [layn_pkg::DATA_W-1:0]     out_row_mean,
  output logic [layn_pkg::DATA_W-1:0]            out_row_variance,
  output logic                                   out_last_of_row,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [layn_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [layn_pkg::CFG_DATA_W-1:0]        cfg_wdata
);
  import layn_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MEAN, S_VRD, S_VSQ, S_VACC, S_VDIV, S_SQRT,
    S_ERD, S_EDEV, S_EDIV, S_EMUL, S_EOUT
  } state_t;

  state_t state_r;

  // configuration registers
  logic [CNT_W-1:0] row_length_r;
  logic [EPS_W-1:0] epsilon_r;
  logic             use_scale_r;
  logic             use_bias_r;

  // row gathering
  logic [CNT_W-1:0]        count_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [CNT_W-1:0]        n_r;
  logic [ADDR_W-1:0]       k_r;

  // statistics
  logic signed [DATA_W-1:0]  mean_r;
  logic [ACC_W-1:0]          acc_r;
  logic                      vsat_r;
  logic [2*DATA_W-1:0]       sq_r;
  logic [DATA_W-1:0]         var_r;
  logic [SQ_ROOT_W-1:0]      s_r;
  logic                      sum_neg_r;

  // emit path
  logic signed [DATA_W:0]    dev_r;
  logic signed [DATA_W-1:0]  q_r;
  logic signed [DATA_W-1:0]  sc_r;
  logic signed [DATA_W-1:0]  bias_r;
  logic [2*DATA_W-1:0]       pm_r;

  // output register
  logic                      out_valid_r;
  logic signed [DATA_W-1:0]  out_norm_r;
  logic signed [DATA_W-1:0]  out_mean_r;
  logic [DATA_W-1:0]         out_var_r;
  logic                      out_last_r;

  // row buffer: {bias, scale, value}
  logic [MEM_W-1:0]  mem [MAX_ROW];
  logic [MEM_W-1:0]  rd_data_r;
  logic [ADDR_W-1:0] rd_addr;
  logic              rd_en;

  // shared units
  logic                 div_go_r;
  logic [DIV_NUM_W-1:0] div_num_r;
  logic [DIV_DEN_W-1:0] div_den_r;
  logic                 div_done;
  logic [DIV_NUM_W-1:0] div_quo;
  logic                 sq_go_r;
  logic [SQ_RAD_W-1:0]  sq_rad_r;
  logic                 sq_done;
  logic [SQ_ROOT_W-1:0] sq_root;

  // combinational helpers
  logic                     in_acc;
  logic [ADDR_W-1:0]        wr_idx;
  logic [CNT_W-1:0]         cnt_new;
  logic [CNT_W-1:0]         len_eff;
  logic signed [SUM_W-1:0]  sum_nxt;
  logic [SUM_W-1:0]         sum_mag;
  logic signed [DATA_W-1:0] rd_value;
  logic signed [DATA_W:0]   dev;
  logic [DATA_W:0]          dev_mag;
  logic [DATA_W:0]          devr_mag;
  logic [ACC_W-1:0]         acc_nxt;
  logic [DATA_W-1:0]        var_nxt;
  logic [DATA_W:0]          var_eps;
  logic [DATA_W-1:0]        q_mag;
  logic [DATA_W-1:0]        sc_mag;
  logic signed [DATA_W-1:0] q_scaled;
  logic signed [DATA_W:0]   q_biased_w;
  logic signed [DATA_W-1:0] q_final;
  logic                     out_free;
  logic                     k_last;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign wr_idx  = count_r[ADDR_W-1:0];
  assign cnt_new = {1'b0, wr_idx} + 1'b1;

  // clamp row length: zero counts as one, anything above the buffer as full
  always_comb begin
    if (row_length_r == '0) len_eff = CNT_W'(1);
    else if (row_length_r > CNT_W'(MAX_ROW)) len_eff = CNT_W'(MAX_ROW);
    else len_eff = row_length_r;
  end

  assign sum_nxt = sum_r + SUM_W'(in_value);
  assign sum_mag = sum_nxt[SUM_W-1] ? SUM_W'(-sum_nxt) : SUM_W'(sum_nxt);

  assign rd_value = $signed(rd_data_r[DATA_W-1:0]);
  assign dev      = (DATA_W+1)'(rd_value) - (DATA_W+1)'(mean_r);
  assign dev_mag  = dev[DATA_W] ? (DATA_W+1)'(-dev) : (DATA_W+1)'(dev);
  assign devr_mag = dev_r[DATA_W] ? (DATA_W+1)'(-dev_r) : (DATA_W+1)'(dev_r);

  assign acc_nxt = acc_r + ACC_W'(sq_r[2*DATA_W-1:16]);

  // saturate the variance to 32 bits
  always_comb begin
    if (vsat_r || (div_quo[DIV_NUM_W-1:DATA_W] != '0)) var_nxt = '1;
    else var_nxt = div_quo[DATA_W-1:0];
  end
  assign var_eps = {1'b0, var_nxt} + (DATA_W+1)'(epsilon_r);

  assign q_mag  = q_r[DATA_W-1] ? DATA_W'(-q_r) : DATA_W'(q_r);
  assign sc_mag = sc_r[DATA_W-1] ? DATA_W'(-sc_r) : DATA_W'(sc_r);

  assign q_scaled = use_scale_r ?
      sat_mag(q_r[DATA_W-1] != sc_r[DATA_W-1],
              DIV_NUM_W'(pm_r[2*DATA_W-1:16])) : q_r;
  assign q_biased_w = (DATA_W+1)'(q_scaled) + (DATA_W+1)'(bias_r);

  always_comb begin
    if (!use_bias_r) q_final = q_scaled;
    else if (q_biased_w > (DATA_W+1)'(DATA_MAX)) q_final = DATA_MAX;
    else if (q_biased_w < (DATA_W+1)'(DATA_MIN)) q_final = DATA_MIN;
    else q_final = q_biased_w[DATA_W-1:0];
  end

  assign out_free = !out_valid_r || !out_stall;
  assign k_last   = ({1'b0, k_r} == (n_r - 1'b1));

  assign rd_en   = (state_r == S_VRD) || (state_r == S_ERD);
  assign rd_addr = k_r;

  // row buffer
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mem[wr_idx] <= {in_bias_value, in_scale_value, in_value};
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  layn_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_go_r),
    .num   (div_num_r),
    .den   (div_den_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  layn_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_go_r),
    .rad   (sq_rad_r),
    .done  (sq_done),
    .root  (sq_root)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_length_r <= ROW_LEN_RESET;
      epsilon_r    <= EPS_RESET;
      use_scale_r  <= 1'b0;
      use_bias_r   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ROW_LENGTH: row_length_r <= cfg_wdata[CNT_W-1:0];
        CFG_EPSILON:    epsilon_r    <= cfg_wdata[EPS_W-1:0];
        CFG_USE_SCALE:  use_scale_r  <= cfg_wdata[0];
        CFG_USE_BIAS:   use_bias_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // main sequencer with its registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
      div_go_r    <= 1'b0;
      sq_go_r     <= 1'b0;
    end else begin
      // pulse the divider on row completion, after the variance sum and
      // for each element with a nonzero root; pulse the root after variance
      div_go_r <= ((state_r == S_IDLE) && in_acc && (cnt_new >= len_eff)) ||
                  ((state_r == S_VACC) && k_last) ||
                  ((state_r == S_EDEV) && (s_r != '0));
      sq_go_r  <= (state_r == S_VDIV) && div_done;
      // drop an accepted result unless the emit pass refills the register
      if (out_valid_r && !out_stall && (state_r != S_EOUT)) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (cnt_new >= len_eff) begin
              // row complete: start the mean division, clear the gatherer
              n_r       <= cnt_new;
              sum_neg_r <= sum_nxt[SUM_W-1];
              div_num_r <= DIV_NUM_W'(sum_mag);
              div_den_r <= DIV_DEN_W'(cnt_new);
              count_r   <= '0;
              sum_r     <= '0;
              state_r   <= S_MEAN;
            end else begin
              count_r <= cnt_new;
              sum_r   <= sum_nxt;
            end
          end
        end
        S_MEAN: begin
          if (div_done) begin
            mean_r  <= sat_mag(sum_neg_r, div_quo);
            k_r     <= '0;
            acc_r   <= '0;
            vsat_r  <= 1'b0;
            state_r <= S_VRD;
          end
        end
        S_VRD: state_r <= S_VSQ;
        S_VSQ: begin
          if (dev_mag[DATA_W]) vsat_r <= 1'b1;
          sq_r    <= dev_mag[DATA_W-1:0] * dev_mag[DATA_W-1:0];
          state_r <= S_VACC;
        end
        S_VACC: begin
          acc_r <= acc_nxt;
          if (k_last) begin
            div_num_r <= DIV_NUM_W'(acc_nxt);
            div_den_r <= DIV_DEN_W'(n_r);
            state_r   <= S_VDIV;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_VRD;
          end
        end
        S_VDIV: begin
          if (div_done) begin
            var_r    <= var_nxt;
            sq_rad_r <= {1'b0, var_eps, 16'b0};
            state_r  <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sq_done) begin
            s_r     <= sq_root;
            k_r     <= '0;
            state_r <= S_ERD;
          end
        end
        S_ERD: state_r <= S_EDEV;
        S_EDEV: begin
          dev_r  <= dev;
          sc_r   <= $signed(rd_data_r[2*DATA_W-1:DATA_W]);
          bias_r <= $signed(rd_data_r[3*DATA_W-1:2*DATA_W]);
          if (s_r == '0) begin
            // zero root: push to the rail in the direction of the deviation
            if (dev_mag == '0) q_r <= '0;
            else if (dev[DATA_W]) q_r <= DATA_MIN;
            else q_r <= DATA_MAX;
            state_r <= S_EMUL;
          end else begin
            div_num_r <= DIV_NUM_W'({dev_mag, 16'b0});
            div_den_r <= s_r;
            state_r   <= S_EDIV;
          end
        end
        S_EDIV: begin
          if (div_done) begin
            q_r     <= sat_mag(dev_r[DATA_W] && (devr_mag != '0), div_quo);
            state_r <= S_EMUL;
          end
        end
        S_EMUL: begin
          pm_r    <= q_mag * sc_mag;
          state_r <= S_EOUT;
        end
        S_EOUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_norm_r  <= q_final;
            out_mean_r  <= mean_r;
            out_var_r   <= var_r;
            out_last_r  <= k_last;
            if (k_last) begin
              state_r <= S_IDLE;
            end else begin
              k_r     <= k_r + 1'b1;
              state_r <= S_ERD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_normalized   = out_norm_r;
  assign out_row_mean     = out_mean_r;
  assign out_row_variance = out_var_r;
  assign out_last_of_row  = out_last_r;

endmodule

// ===== rtl/layn_check.sv =====
// ----------------------------------------------------------------------------
// layn_check
// Port-level checks for the row layer normalization block, bound to the top.
// ----------------------------------------------------------------------------
module layn_check (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic signed [layn_pkg::DATA_W-1:0]  in_value,
  input logic signed [layn_pkg::DATA_W-1:0]  in_scale_value,
  input logic signed [layn_pkg::DATA_W-1:0]  in_bias_value,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [layn_pkg::DATA_W-1:0]  out_normalized,
  input logic signed [layn_pkg::DATA_W-1:0]  out_row_mean,
  input logic [layn_pkg::DATA_W-1:0]         out_row_variance,
  input logic                                out_last_of_row,
  input logic                                cfg_valid,
  input logic                                cfg_ready,
  input logic [layn_pkg::CFG_IDX_W-1:0]      cfg_index,
  input logic [layn_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its normalized value and last flag
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_normalized) && $stable(out_last_of_row))
    else $error("stalled result changed");

  // mid-row results mean the emit pass is still running, so input stays closed
  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_of_row |=> in_stall)
    else $error("input opened before the row was emitted");

  // reset drops any pending result
  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result survived reset");

endmodule

bind layer_normalization_row layn_check u_layn_check (.*);

// ===== sim/layer_normalization_row_tb.sv =====
// ----------------------------------------------------------------------------
// layer_normalization_row_tb
// Drives rows of Q16.16 elements with random burst gaps and random result
// stalls. An in-bench model predicts each normalized element, mean and
// variance. A scoreboard compares every result transaction in order.
// ----------------------------------------------------------------------------
module layer_normalization_row_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import layn_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_IDX   = 3'd7;
  localparam longint signed S32_MAX = 64'sd2147483647;
  localparam longint signed S32_MIN = -64'sd2147483648;
  localparam longint signed S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

  // One normalized element as the result channel carries it.
  typedef struct {
    logic signed [DATA_W-1:0] norm;
    logic signed [DATA_W-1:0] mean;
    logic [DATA_W-1:0]        variance;
    logic                     last;
  } norm_result_t;

  // Directed stimulus row: a register write or an element, with an optional
  // hand-written expectation for single-element rows.
  typedef struct {
    bit                       is_cfg;
    logic [CFG_IDX_W-1:0]     idx;
    logic [CFG_DATA_W-1:0]    wdata;
    logic signed [DATA_W-1:0] v;
    logic signed [DATA_W-1:0] s;
    logic signed [DATA_W-1:0] b;
    bit                       typed;
    norm_result_t             want;
  } dir_row_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [DATA_W-1:0] in_value = '0;
  logic signed [DATA_W-1:0] in_scale_value = '0;
  logic signed [DATA_W-1:0] in_bias_value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] out_normalized;
  logic signed [DATA_W-1:0] out_row_mean;
  logic [DATA_W-1:0]        out_row_variance;
  logic                     out_last_of_row;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_DATA_W-1:0]    cfg_wdata = '0;

  layer_normalization_row u_top (.*);

  always #5 clk = ~clk;

  // Shadow registers and row buffer of the predictor.
  logic [6:0]     len_reg;
  logic [15:0]    eps_reg;
  bit             scale_on, bias_on;
  longint signed  row_vals[MAX_ROW], row_scales[MAX_ROW], row_biases[MAX_ROW];
  int unsigned    row_fill;
  longint signed  row_sum;

  norm_result_t   pending_q[$];
  int             fail_cnt = 0;
  int             items_sent = 0;
  int             burst_left = 0;
  int             stall_mode = 0;

  function automatic longint unsigned magnitude(longint signed v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint signed signed_of(bit neg, longint unsigned m);
    if (m > 64'(S64_MAX)) m = 64'(S64_MAX);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint signed clip32(longint signed v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, bt;
    r = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt >>= 2;
    while (bt != 0) begin
      if (v >= r + bt) begin
        v -= r + bt;
        r = (r >> 1) + bt;
      end else begin
        r >>= 1;
      end
      bt >>= 2;
    end
    return r;
  endfunction

  function automatic void shadow_write(logic [CFG_IDX_W-1:0] idx, logic [15:0] d);
    case (idx)
      CFG_ROW_LENGTH: len_reg = d[6:0];
      CFG_EPSILON:    eps_reg = d;
      CFG_USE_SCALE:  scale_on = d[0];
      CFG_USE_BIAS:   bias_on = d[0];
      default: ;
    endcase
  endfunction

  // Buffer one element; on row completion queue one result per element.
  function automatic void normalize_element(logic signed [31:0] v,
                                            logic signed [31:0] sc,
                                            logic signed [31:0] bi);
    int unsigned slot, lim, n;
    longint signed mean, d, q;
    longint unsigned acc, variance, root, dm;
    bit var_sat;
    norm_result_t r;
    slot = row_fill % MAX_ROW;
    row_vals[slot] = v;
    row_scales[slot] = sc;
    row_biases[slot] = bi;
    row_sum += v;
    row_fill = slot + 1;
    lim = len_reg;
    if (lim == 0) lim = 1;
    if (lim > MAX_ROW) lim = MAX_ROW;
    if (row_fill < lim) return;
    n = row_fill;
    mean = signed_of(row_sum < 0, magnitude(row_sum) / n);
    acc = 0;
    var_sat = 0;
    for (int k = 0; k < n; k++) begin
      dm = magnitude(row_vals[k] - mean);
      if (dm >= (64'd1 << 32)) var_sat = 1;
      else acc += (dm * dm) >> 16;
    end
    variance = var_sat ? 64'hFFFF_FFFF : acc / n;
    if (variance > 64'hFFFF_FFFF) variance = 64'hFFFF_FFFF;
    root = int_sqrt((variance + eps_reg) << 16);
    for (int k = 0; k < n; k++) begin
      d = row_vals[k] - mean;
      if (root == 0) begin
        q = d > 0 ? S32_MAX : (d < 0 ? S32_MIN : 0);
      end else begin
        dm = magnitude(d);
        if (dm > (64'd1 << 47) - 1) dm = (64'd1 << 47) - 1;
        q = clip32(signed_of(d < 0, (dm << 16) / root));
      end
      if (scale_on)
        q = clip32(signed_of((q < 0) != (row_scales[k] < 0),
                             (magnitude(q) * magnitude(row_scales[k])) >> 16));
      if (bias_on) q = clip32(q + row_biases[k]);
      r.norm = q[31:0];
      r.mean = mean[31:0];
      r.variance = variance[31:0];
      r.last = (k + 1 == n);
      pending_q.push_back(r);
    end
    row_fill = 0;
    row_sum = 0;
  endfunction

  // Send one element; bursts end in a random gap with valid low.
  task automatic send_element(logic signed [31:0] v, logic signed [31:0] sc,
                              logic signed [31:0] bi);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_value <= v;
    in_scale_value <= sc;
    in_bias_value <= bi;
    do @(posedge clk); while (in_stall);
    normalize_element(v, sc, bi);
    items_sent++;
  endtask

  // Drop valid and hold until every queued result is back.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending_q.size() == 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    do @(posedge clk); while (!cfg_ready);
    shadow_write(idx, d);
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic dir_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [15:0] d);
    dir_row_t t;
    t = '{default: '0};
    t.is_cfg = 1;
    t.idx = idx;
    t.wdata = d;
    return t;
  endfunction

  function automatic dir_row_t elem_row(logic signed [31:0] v, logic signed [31:0] sc,
                                        logic signed [31:0] bi);
    dir_row_t t;
    t = '{default: '0};
    t.v = v;
    t.s = sc;
    t.b = bi;
    return t;
  endfunction

  function automatic dir_row_t fixed_row(logic signed [31:0] v, logic signed [31:0] bi,
                                         logic signed [31:0] nrm);
    dir_row_t t;
    t = elem_row(v, ONE_Q16, bi);
    t.typed = 1;
    t.want = '{norm: nrm, mean: v, variance: 32'd0, last: 1'b1};
    return t;
  endfunction

  function automatic logic signed [31:0] pick_value(int mode, logic signed [31:0] base);
    case (mode)
      0: return $urandom;
      1: return base + $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      default: begin
        case ($urandom_range(0, 3))
          0: return DATA_MAX;
          1: return DATA_MIN;
          2: return '0;
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  // Receiver: stall pattern changes with the phase, including no stalls.
  always @(negedge clk) begin
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 9) < 3);
      2: out_stall <= ($urandom_range(0, 9) < 8);
      default: out_stall <= ~out_stall;
    endcase
  end

  // Scoreboard: compare each result transaction with the oldest prediction.
  always @(posedge clk) begin
    norm_result_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result norm=%h", $time, out_normalized);
        fail_cnt++;
      end else begin
        w = pending_q.pop_front();
        if (out_normalized !== w.norm) begin
          $display("%0t: normalized exp %h got %h", $time, w.norm, out_normalized);
          fail_cnt++;
        end
        if (out_row_mean !== w.mean) begin
          $display("%0t: row_mean exp %h got %h", $time, w.mean, out_row_mean);
          fail_cnt++;
        end
        if (out_row_variance !== w.variance) begin
          $display("%0t: row_variance exp %h got %h", $time, w.variance,
                   out_row_variance);
          fail_cnt++;
        end
        if (out_last_of_row !== w.last) begin
          $display("%0t: last_of_row exp %b got %b", $time, w.last, out_last_of_row);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog.
  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

  initial begin
    dir_row_t dir_tab[$];
    int rows, lim, mode, cut;
    logic signed [31:0] base;
    logic [15:0] len_w;

    len_reg = ROW_LEN_RESET;
    eps_reg = EPS_RESET;
    scale_on = 0;
    bias_on = 0;
    row_fill = 0;
    row_sum = 0;

    // Single-element rows: deviation is zero, so the result is the bias.
    dir_tab.push_back(reg_row(CFG_ROW_LENGTH, 16'd1));
    dir_tab.push_back(reg_row(CFG_USE_BIAS, 16'd1));
    dir_tab.push_back(fixed_row(DATA_MAX, 32'sh1234_5678, 32'sh1234_5678));
    dir_tab.push_back(fixed_row(DATA_MIN, DATA_MIN, DATA_MIN));
    // Epsilon 0: a single element and a flat row give a zero root; a row of both extremes sits between.
    dir_tab.push_back(reg_row(CFG_EPSILON, 16'd0));
    dir_tab.push_back(reg_row(CFG_USE_BIAS, 16'd0));
    dir_tab.push_back(fixed_row(32'sd5, 32'sd0, 32'sd0));
    dir_tab.push_back(reg_row(CFG_ROW_LENGTH, 16'd2));
    dir_tab.push_back(elem_row(DATA_MAX, 0, 0));
    dir_tab.push_back(elem_row(DATA_MIN, 0, 0));
    dir_tab.push_back(elem_row(32'sh0001_0000, 0, 0));
    dir_tab.push_back(elem_row(32'sh0001_0000, 0, 0));
    // Extremes with scale and bias, widest epsilon.
    dir_tab.push_back(reg_row(CFG_EPSILON, 16'hFFFF));
    dir_tab.push_back(reg_row(CFG_USE_SCALE, 16'd1));
    dir_tab.push_back(reg_row(CFG_USE_BIAS, 16'hFFFF));
    dir_tab.push_back(reg_row(CFG_ROW_LENGTH, 16'd4));
    dir_tab.push_back(elem_row(DATA_MIN, DATA_MAX, DATA_MAX));
    dir_tab.push_back(elem_row(DATA_MAX, DATA_MIN, DATA_MIN));
    dir_tab.push_back(elem_row(DATA_MIN, DATA_MIN, DATA_MAX));
    dir_tab.push_back(elem_row(DATA_MAX, DATA_MAX, DATA_MIN));
    // Row length lowered mid-row: the partial row flushes on the next element.
    dir_tab.push_back(reg_row(CFG_ROW_LENGTH, 16'd8));
    dir_tab.push_back(elem_row(32'sh0003_0000, ONE_Q16, 32'sd7));
    dir_tab.push_back(elem_row(-32'sh0002_8000, ONE_Q16, -32'sd7));
    dir_tab.push_back(elem_row(32'sh0000_4000, -32'sh0002_0000, 32'sd0));
    dir_tab.push_back(reg_row(CFG_ROW_LENGTH, 16'd2));
    dir_tab.push_back(elem_row(32'sh0010_0000, 32'sh0000_8000, 32'sd1));
    // Row length zero acts as one; unused indexes must not disturb anything.
    dir_tab.push_back(reg_row(CFG_ROW_LENGTH, 16'hFF80));
    dir_tab.push_back(reg_row(CFG_SPARE_IDX, 16'hFFFF));
    dir_tab.push_back(reg_row(CFG_TOP_IDX, 16'h0000));
    dir_tab.push_back(elem_row(32'sh7654_3210, ONE_Q16, 32'sh0000_0100));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        drain_results();
        write_reg(dir_tab[i].idx, dir_tab[i].wdata);
        end_writes();
      end else begin
        send_element(dir_tab[i].v, dir_tab[i].s, dir_tab[i].b);
        if (dir_tab[i].typed) pending_q[$] = dir_tab[i].want;
      end
    end

    // Random phases: new settings, then a few complete rows.
    while (items_sent < 120) begin
      drain_results();
      stall_mode = $urandom_range(0, 3);
      case ($urandom_range(0, 19))
        0: len_w = 16'd64;
        1: len_w = 16'd100;
        2: len_w = 16'd0;
        default: len_w = 16'($urandom_range(1, 8)) | (16'($urandom) & 16'hFF80);
      endcase
      write_reg(CFG_ROW_LENGTH, len_w);
      case ($urandom_range(0, 3))
        0: write_reg(CFG_EPSILON, 16'd0);
        1: write_reg(CFG_EPSILON, 16'hFFFF);
        default: write_reg(CFG_EPSILON, 16'($urandom));
      endcase
      write_reg(CFG_USE_SCALE, 16'($urandom));
      write_reg(CFG_USE_BIAS, 16'($urandom));
      if ($urandom_range(0, 5) == 0) write_reg(CFG_SPARE_IDX, 16'($urandom));
      end_writes();
      lim = len_reg == 0 ? 1 : (len_reg > MAX_ROW ? MAX_ROW : len_reg);
      rows = lim > 8 ? 1 : $urandom_range(1, 3);
      for (int r = 0; r < rows; r++) begin
        mode = $urandom_range(0, 2);
        base = $urandom;
        for (int k = 0; k < lim; k++)
          send_element(pick_value(mode, base),
                       $urandom_range(0, 1) ? 32'($urandom)
                                            : ONE_Q16 + 32'($urandom_range(0, 255)),
                       $urandom);
      end
      // Now and then cut a row short by lowering the length mid-row.
      if (lim >= 3 && lim <= 8 && $urandom_range(0, 3) == 0) begin
        cut = $urandom_range(1, lim - 1);
        for (int k = 0; k < cut; k++) send_element($urandom, $urandom, $urandom);
        drain_results();
        write_reg(CFG_ROW_LENGTH, 16'($urandom_range(1, cut)));
        end_writes();
        send_element($urandom, $urandom, $urandom);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending_q.size() == 0);
    repeat (50) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/layn_pkg.sv
rtl/layn_div.sv
rtl/layn_sqrt.sv
rtl/layer_normalization_row.sv
rtl/layn_check.sv
sim/layer_normalization_row_tb.sv
